// ===== design/assert_macros.svh =====
// Concurrent assertion helpers included by dmwc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== design/dmwc_pkg.sv =====
package dmwc_pkg;

    localparam int ADDR_W          = 16;
    localparam int WORD_W          = 32;
    localparam int CFG_W           = 8;
    localparam int COST_W          = 10;
    localparam int NUM_LINES       = 256;
    localparam int WORDS_PER_BLOCK = 16;
    localparam int MEMORY_WORDS    = 16384;

    localparam int WADDR_W = ADDR_W - 2;
    localparam int OFF_W   = $clog2(WORDS_PER_BLOCK);
    localparam int IDX_W   = $clog2(NUM_LINES);
    localparam int TAG_W   = WADDR_W - OFF_W - IDX_W;
    localparam int LINE_AW = IDX_W + OFF_W;
    localparam int MEM_AW  = $clog2(MEMORY_WORDS);
    localparam int PADDR_W = 4;

    localparam logic [MEM_AW-1:0] MEM_LAST   = MEM_AW'(MEMORY_WORDS - 1);
    localparam logic [OFF_W:0]    BEAT_LAST  = (OFF_W + 1)'(WORDS_PER_BLOCK);

    // Action codes
    localparam logic [1:0] ACT_READ    = 2'd0;
    localparam logic [1:0] ACT_WRITE   = 2'd1;
    localparam logic [1:0] ACT_PRELOAD = 2'd2;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_MEM_READ_COST    = 2'd0;
    localparam logic [1:0] REG_MEM_WRITE_COST   = 2'd1;
    localparam logic [1:0] REG_CACHE_READ_COST  = 2'd2;
    localparam logic [1:0] REG_CACHE_WRITE_COST = 2'd3;

    localparam logic [CFG_W-1:0] RST_MEM_READ_COST    = 8'd100;
    localparam logic [CFG_W-1:0] RST_MEM_WRITE_COST   = 8'd50;
    localparam logic [CFG_W-1:0] RST_CACHE_READ_COST  = 8'd1;
    localparam logic [CFG_W-1:0] RST_CACHE_WRITE_COST = 8'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TAG_RD,
        ST_TAG_CHK,
        ST_WB,
        ST_FETCH,
        ST_SERVE,
        ST_PRELOAD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              busy;
        logic              accept;
        logic              clearing;
        logic [MEM_AW-1:0] clr_addr;
        logic              preload_we;
        logic              tag_chk;
        logic              wb_we;
        logic              fetch_we;
        logic [OFF_W-1:0]  beat_rd;
        logic [OFF_W-1:0]  beat_wr;
        logic              serve;
        logic              finish;
    } ctrl_t;

    typedef struct packed {
        logic hit;
        logic victim_dirty;
    } stat_t;

endpackage

// ===== design/dmwc_ram.sv =====
module dmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/dmwc_seq.sv =====
module dmwc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [1:0]      action,
    input  dmwc_pkg::stat_t stat,
    output dmwc_pkg::ctrl_t ctrl
);

    import dmwc_pkg::*;

    state_t            state_reg, state_next;
    logic [OFF_W:0]    cnt_reg, cnt_next;
    logic [MEM_AW-1:0] clr_reg, clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        ctrl          = '0;
        ctrl.busy     = (state_reg != ST_IDLE);
        ctrl.clr_addr = clr_reg;
        ctrl.beat_rd  = cnt_reg[OFF_W-1:0];
        ctrl.beat_wr  = cnt_reg[OFF_W-1:0] - 1'b1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero backing memory one word a cycle
                ctrl.clearing = 1'b1;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == MEM_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.accept = 1'b1;
                    unique case (action) inside
                        ACT_READ, ACT_WRITE: state_next = ST_TAG_RD;
                        ACT_PRELOAD:         state_next = ST_PRELOAD;
                        default:             state_next = ST_FINISH;
                    endcase
                end
            end
            ST_TAG_RD:
            begin
                state_next = ST_TAG_CHK;
            end
            ST_TAG_CHK:
            begin
                ctrl.tag_chk = 1'b1;
                cnt_next     = '0;
                if (stat.hit)
                begin
                    state_next = ST_SERVE;
                end
                else if (stat.victim_dirty)
                begin
                    state_next = ST_WB;
                end
                else
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_WB:
            begin
                // read line word k, write back word k-1 from the registered line read data
                ctrl.wb_we = (cnt_reg != '0);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == BEAT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                ctrl.fetch_we = (cnt_reg != '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == BEAT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                ctrl.serve = 1'b1;
                state_next = ST_FINISH;
            end
            ST_PRELOAD:
            begin
                ctrl.preload_we = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                ctrl.finish = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/direct_mapped_writeback_cache_unit.sv =====
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+----------------------------
// request  | action, address, write_data                   | start && !busy
// result   | read_data, hit, wrote_back, access_cost       | done (one cycle, no stall)
// config   | psel, penable, pwrite, paddr, pwdata, prdata  | psel && penable && pwrite
//
// Hit: tag read, tag check, serve and finish states, then the registered
// result; preload: preload and finish states; unused action: finish only.
// Miss adds a block fetch, preceded by a write-back when the victim is
// dirty, one word per cycle through the line and backing memory ports.
// After reset, busy stays high while backing memory is zeroed.
// Results cannot be stalled; the next request may transfer while one is shown.
module direct_mapped_writeback_cache_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [dmwc_pkg::ADDR_W-1:0]  address,
    input  logic [dmwc_pkg::WORD_W-1:0]  write_data,
    output logic                         done,
    output logic [dmwc_pkg::WORD_W-1:0]  read_data,
    output logic                         hit,
    output logic                         wrote_back,
    output logic [dmwc_pkg::COST_W-1:0]  access_cost,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dmwc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    import dmwc_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    logic [CFG_W-1:0] mem_read_cost_reg, mem_write_cost_reg;
    logic [CFG_W-1:0] cache_read_cost_reg, cache_write_cost_reg;
    logic [CFG_W-1:0] prd_sel;

    logic [1:0]        action_reg;
    logic [WADDR_W-1:0] waddr_reg;
    logic [WORD_W-1:0] wdata_reg;
    logic [OFF_W-1:0]  off;
    logic [IDX_W-1:0]  idx;
    logic [TAG_W-1:0]  tag;

    logic [NUM_LINES-1:0] valid_reg;
    logic              hit_reg, vdirty_reg;
    logic [TAG_W-1:0]  vtag_reg;
    logic              is_read, is_write, is_access;

    logic [TAG_W:0]    tag_rdata, tag_wdata;
    logic              line_valid;

    logic              line_we;
    logic [LINE_AW-1:0] line_waddr, line_raddr;
    logic [WORD_W-1:0] line_wdata, line_rdata;

    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    logic [COST_W-1:0] cost_sum;

    logic              done_reg, hit_out_reg, wb_out_reg;
    logic [WORD_W-1:0] rdata_out_reg;
    logic [COST_W-1:0] cost_out_reg;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_read_cost_reg    <= RST_MEM_READ_COST;
            mem_write_cost_reg   <= RST_MEM_WRITE_COST;
            cache_read_cost_reg  <= RST_CACHE_READ_COST;
            cache_write_cost_reg <= RST_CACHE_WRITE_COST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_MEM_READ_COST:    mem_read_cost_reg    <= pwdata[CFG_W-1:0];
                REG_MEM_WRITE_COST:   mem_write_cost_reg   <= pwdata[CFG_W-1:0];
                REG_CACHE_READ_COST:  cache_read_cost_reg  <= pwdata[CFG_W-1:0];
                REG_CACHE_WRITE_COST: cache_write_cost_reg <= pwdata[CFG_W-1:0];
                default:              mem_read_cost_reg    <= mem_read_cost_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MEM_READ_COST:    prd_sel = mem_read_cost_reg;
            REG_MEM_WRITE_COST:   prd_sel = mem_write_cost_reg;
            REG_CACHE_READ_COST:  prd_sel = cache_read_cost_reg;
            REG_CACHE_WRITE_COST: prd_sel = cache_write_cost_reg;
            default:              prd_sel = '0;
        endcase
    end

    assign prdata = 32'(prd_sel);

    // Sequencer
    dmwc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .ctrl   (ctrl)
    );

    assign busy = ctrl.busy;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            action_reg <= action;
            waddr_reg  <= address[ADDR_W-1:2];
            wdata_reg  <= write_data;
        end
    end

    assign off = waddr_reg[OFF_W-1:0];
    assign idx = waddr_reg[OFF_W +: IDX_W];
    assign tag = waddr_reg[WADDR_W-1 -: TAG_W];

    assign is_read   = (action_reg == ACT_READ);
    assign is_write  = (action_reg == ACT_WRITE);
    assign is_access = is_read || is_write;

    // Line state: valid in flops, {dirty, tag} in memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctrl.serve)
        begin
            valid_reg[idx] <= 1'b1;
        end
    end

    assign line_valid = valid_reg[idx];
    assign tag_wdata  = {is_write || (hit_reg && vdirty_reg), tag};

    dmwc_ram #(
        .WIDTH (TAG_W + 1),
        .DEPTH (NUM_LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ctrl.serve),
        .waddr (idx),
        .wdata (tag_wdata),
        .raddr (idx),
        .rdata (tag_rdata)
    );

    assign stat.hit          = line_valid && (tag_rdata[TAG_W-1:0] == tag);
    assign stat.victim_dirty = line_valid && tag_rdata[TAG_W];

    always_ff @(posedge clk)
    begin
        if (ctrl.tag_chk)
        begin
            hit_reg    <= stat.hit;
            vdirty_reg <= stat.victim_dirty;
            vtag_reg   <= tag_rdata[TAG_W-1:0];
        end
    end

    // Line word memory
    always_comb
    begin
        line_raddr = {idx, ctrl.beat_rd};
        line_waddr = {idx, ctrl.beat_wr};
        line_wdata = mem_rdata;
        if (ctrl.serve)
        begin
            line_raddr = {idx, off};
            line_waddr = {idx, off};
            line_wdata = wdata_reg;
        end
    end

    assign line_we = ctrl.fetch_we || (ctrl.serve && is_write);

    dmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_LINES * WORDS_PER_BLOCK)
    ) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    // Backing memory
    always_comb
    begin
        if (ctrl.clearing)
        begin
            mem_waddr = ctrl.clr_addr;
            mem_wdata = '0;
        end
        else if (ctrl.preload_we)
        begin
            mem_waddr = MEM_AW'(waddr_reg);
            mem_wdata = wdata_reg;
        end
        else
        begin
            // victim block rebuilt from stored tag and line index
            mem_waddr = MEM_AW'({vtag_reg, idx, ctrl.beat_wr});
            mem_wdata = line_rdata;
        end
    end

    assign mem_we    = ctrl.clearing || ctrl.preload_we || ctrl.wb_we;
    assign mem_raddr = MEM_AW'({tag, idx, ctrl.beat_rd});

    dmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEMORY_WORDS)
    ) u_mem_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result
    assign cost_sum = (hit_reg ? '0 : COST_W'(mem_read_cost_reg))
                    + ((!hit_reg && vdirty_reg) ? COST_W'(mem_write_cost_reg) : '0)
                    + (is_read ? COST_W'(cache_read_cost_reg)
                               : COST_W'(cache_write_cost_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            rdata_out_reg <= is_read ? line_rdata : '0;
            hit_out_reg   <= is_access && hit_reg;
            wb_out_reg    <= is_access && !hit_reg && vdirty_reg;
            cost_out_reg  <= is_access ? cost_sum : '0;
        end
    end

    assign done        = done_reg;
    assign read_data   = rdata_out_reg;
    assign hit         = hit_out_reg;
    assign wrote_back  = wb_out_reg;
    assign access_cost = cost_out_reg;

endmodule

// ===== design/dmwc_checker.sv =====
`include "assert_macros.svh"

module dmwc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        hit,
    input logic                        wrote_back,
    input logic [dmwc_pkg::COST_W-1:0] access_cost
);

    import dmwc_pkg::*;

    // a transfer always leaves the idle state
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // no result strobe right after a transfer
    `ASSERT_NEXT(a_accept_no_done, clk, rst_n, start && !busy, !done)
    // a result only follows a busy cycle
    `ASSERT_ALWAYS(a_done_after_busy, clk, rst_n, !done || $past(busy))
    // a write-back happens only on a miss
    `ASSERT_ALWAYS(a_wb_on_miss, clk, rst_n, !(done && wrote_back && hit))

endmodule

bind direct_mapped_writeback_cache_unit dmwc_checker u_dmwc_checker (.*);
